>>> hw/rtl/y86_pkg.sv
// shared types and constants for the y86 executor
package y86_pkg;
  localparam int MEM_BYTES = 4096;
  localparam int AW = $clog2(MEM_BYTES);
  localparam int CLR_W = AW + 1;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_EXEC = 2'd1;
  localparam logic [1:0] MODE_RDMEM = 2'd2;
  localparam logic [1:0] MODE_RDREG = 2'd3;

  localparam logic [1:0] ST_AOK = 2'd0;
  localparam logic [1:0] ST_HLT = 2'd1;
  localparam logic [1:0] ST_ADR = 2'd2;
  localparam logic [1:0] ST_INS = 2'd3;

  localparam logic [3:0] I_HALT = 4'h0;
  localparam logic [3:0] I_NOP = 4'h1;
  localparam logic [3:0] I_RRMOV = 4'h2;
  localparam logic [3:0] I_IRMOV = 4'h3;
  localparam logic [3:0] I_RMMOV = 4'h4;
  localparam logic [3:0] I_MRMOV = 4'h5;
  localparam logic [3:0] I_OP = 4'h6;
  localparam logic [3:0] I_JXX = 4'h7;
  localparam logic [3:0] I_CALL = 4'h8;
  localparam logic [3:0] I_RET = 4'h9;
  localparam logic [3:0] I_PUSH = 4'hA;
  localparam logic [3:0] I_POP = 4'hB;

  localparam logic [3:0] RNONE = 4'hF;
  localparam logic [2:0] ESP_IDX = 3'd4;
  localparam logic [31:0] LAST_WORD = 32'(MEM_BYTES - 4);

  // memory port request
  typedef struct packed {
    logic           we;
    logic [AW-1:0]  addr;
    logic [7:0]     wdata;
  } mem_req_t;

  // condition evaluation: bit1 valid, bit0 taken
  function automatic logic [1:0] cond_eval(input logic [2:0] cc, input logic [3:0] f);
    logic z, s, o, lt;
    z = cc[2]; s = cc[1]; o = cc[0]; lt = s ^ o;
    unique case (f)
      4'd0: cond_eval = 2'b11;
      4'd1: cond_eval = {1'b1, lt | z};
      4'd2: cond_eval = {1'b1, lt};
      4'd3: cond_eval = {1'b1, z};
      4'd4: cond_eval = {1'b1, ~z};
      4'd5: cond_eval = {1'b1, ~lt};
      4'd6: cond_eval = {1'b1, ~lt & ~z};
      default: cond_eval = 2'b00;
    endcase
  endfunction
endpackage

>>> hw/rtl/y86_mem.sv
// byte-wide main memory, one port, registered read
module y86_mem import y86_pkg::*; (
  input  logic       clk,
  input  mem_req_t   req,
  output logic [7:0] rdata
);
  logic [7:0] ram [MEM_BYTES];

  // write or read one byte per cycle
  always_ff @(posedge clk) begin
    if (req.we) begin
      ram[req.addr] <= req.wdata;
    end
    rdata <= ram[req.addr];
  end
endmodule

>>> hw/rtl/y86_instruction_executor.sv
// top level: y86 sequencer around a byte memory and register file
// channel | dir | tdata fields (low first)                                | tuser
// s_axis  | in  | mode[1:0] address[13:2] load_byte[21:14] reg_idx[24:22] | -
// m_axis  | out | status[1:0] pc[33:2] flags[36:34] read_data[68:37]      | -
// after reset every byte of memory is cleared in turn, no input taken meanwhile
// a load or register read goes straight to the result, a word read in range first reads four bytes
// (mrmovl: issue, six fetch bytes, decode, four data bytes and the result, with the bytes one per
// cycle on the memory port)
// a finished transaction waits in the output register while the next is accepted
// reset clears the register file, pc and status at once and sets the flags to zero flag only
module y86_instruction_executor import y86_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // mode, address, load_byte, register_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // status, program_counter, flags, read_data
);
  localparam logic [3:0] S_CLR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_FETCH = 4'd2;
  localparam logic [3:0] S_DEC = 4'd3;
  localparam logic [3:0] S_DRD = 4'd4;
  localparam logic [3:0] S_DWR = 4'd5;
  localparam logic [3:0] S_WORD = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;

  logic [3:0] state;
  logic [CLR_W-1:0] clr_cnt;
  logic [31:0] regs [8];
  logic [31:0] pc;
  logic [2:0] cc;
  logic [1:0] run_st;

  logic [1:0] mode;
  logic [AW-1:0] in_addr;
  logic [11:0] in_addr_raw;
  logic [7:0] in_byte;

  // instruction working registers
  logic [7:0] ibyte [6];
  logic [2:0] fcnt;      // bytes requested
  logic [31:0] ea;
  logic [31:0] wval;
  logic [2:0] dcnt;      // data bytes issued
  logic [31:0] rd_word;

  mem_req_t req;
  logic [7:0] rdata;

  y86_mem u_mem (.clk(clk), .req(req), .rdata(rdata));

  // output register
  logic out_full;
  logic [71:0] out_data;
  logic out_load;
  assign m_axis_tvalid = out_full;
  assign m_axis_tdata = out_data;
  assign s_axis_tready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!out_full || m_axis_tready);

  // load byte is a single write when in range
  logic load_we;
  assign load_we = out_load && (mode == MODE_LOAD) &&
                   (32'(in_addr_raw) < 32'(MEM_BYTES));

  logic [31:0] rd_acc;
  logic [3:0] ic, fn, ra, rb;
  assign ic = ibyte[0][7:4];
  assign fn = ibyte[0][3:0];
  assign ra = ibyte[1][7:4];
  assign rb = ibyte[1][3:0];
  logic [31:0] imm;
  always_comb begin
    if (ic == I_JXX || ic == I_CALL) begin
      imm = {ibyte[4], ibyte[3], ibyte[2], ibyte[1]};
    end else begin
      imm = {ibyte[5], ibyte[4], ibyte[3], ibyte[2]};
    end
  end

  // memory request mux
  logic [31:0] fa;
  assign fa = pc + {29'b0, fcnt};
  always_comb begin
    req = '0;
    unique case (state)
      S_CLR: begin
        req.we = 1'b1;
        req.addr = clr_cnt[AW-1:0];
      end
      S_FETCH: req.addr = fa[AW-1:0];
      S_DRD, S_WORD: req.addr = ea[AW-1:0] + AW'(dcnt);
      S_DWR: begin
        req.we = 1'b1;
        req.addr = ea[AW-1:0] + AW'(dcnt);
        req.wdata = wval[8*dcnt[1:0] +: 8];
      end
      S_DONE: begin
        req.we = load_we;
        req.addr = in_addr;
        req.wdata = in_byte;
      end
      default: req.addr = in_addr;
    endcase
  end

  logic [1:0] ce;
  assign ce = cond_eval(cc, fn);
  logic [31:0] va, vb, vsp, alu, sp_m4, sp_p4;
  assign va = regs[ra[2:0]];
  assign vb = regs[rb[2:0]];
  assign vsp = regs[ESP_IDX];
  assign sp_m4 = vsp - 32'd4;
  assign sp_p4 = vsp + 32'd4;
  logic alu_o;
  always_comb begin
    alu_o = 1'b0;
    unique case (fn[1:0])
      2'd0: begin alu = vb + va; alu_o = ~(va[31] ^ vb[31]) & (alu[31] ^ va[31]); end
      2'd1: begin alu = vb - va; alu_o = (va[31] ^ vb[31]) & (vb[31] ^ alu[31]); end
      2'd2: alu = vb & va;
      default: alu = vb ^ va;
    endcase
  end
  logic [31:0] eab;
  assign eab = vb + imm;
  assign rd_acc = {rdata, rd_word[31:8]};

  // pending data-read destination: 0 mrmov/pop reg, 1 ret pc
  logic [2:0] dst_reg;
  logic dst_pc;
  logic [31:0] dout;

  // length known once the opcode byte is in, or the byte now arriving
  function automatic logic [2:0] flen_next(input logic [2:0] n, input logic [7:0] b);
    logic [3:0] c;
    logic nr, ni;
    c = (n == 3'd1) ? b[7:4] : ibyte[0][7:4];
    nr = !(c == I_HALT || c == I_NOP || c == I_JXX || c == I_CALL || c == I_RET);
    ni = (c == I_IRMOV || c == I_RMMOV || c == I_MRMOV || c == I_JXX || c == I_CALL);
    flen_next = 3'd1 + {2'b0, nr} + (ni ? 3'd4 : 3'd0);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_cnt <= '0;
      for (int i = 0; i < 8; i++) regs[i] <= '0;
      pc <= '0;
      cc <= 3'd4;
      run_st <= ST_AOK;
      out_full <= 1'b0;
    end else begin
      if (out_load) out_full <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) out_full <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLR_W'(MEM_BYTES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            mode <= s_axis_tdata[1:0];
            in_addr_raw <= s_axis_tdata[13:2];
            in_addr <= AW'(s_axis_tdata[13:2]);
            in_byte <= s_axis_tdata[21:14];
            fcnt <= '0;
            dcnt <= '0;
            unique case (s_axis_tdata[1:0])
              MODE_LOAD: begin
                dout <= '0;
                state <= S_DONE;
              end
              MODE_RDREG: begin
                dout <= regs[s_axis_tdata[24:22]];
                state <= S_DONE;
              end
              MODE_RDMEM: begin
                dout <= '0;
                ea <= 32'(s_axis_tdata[13:2]);
                if (32'(s_axis_tdata[13:2]) <= LAST_WORD) state <= S_WORD;
                else state <= S_DONE;
              end
              default: begin
                dout <= '0;
                if (run_st != ST_AOK) state <= S_DONE;
                else if (pc >= 32'(MEM_BYTES)) begin
                  run_st <= ST_ADR; state <= S_DONE;
                end else state <= S_FETCH;
              end
            endcase
          end
        end
        S_FETCH: begin
          // byte for fcnt-1 arrives now
          if (fcnt != 3'd0) ibyte[fcnt - 3'd1] <= rdata;
          if (fcnt != 3'd0 && fcnt == flen_next(fcnt, rdata)) begin
            state <= S_DEC;
          end else if (fa >= 32'(MEM_BYTES)) begin
            run_st <= ST_ADR; state <= S_DONE;
          end else begin
            fcnt <= fcnt + 3'd1;
          end
        end
        S_DEC: begin
          unique case (ic)
            I_HALT: begin run_st <= ST_HLT; state <= S_DONE; end
            I_NOP: begin pc <= pc + 32'd1; state <= S_DONE; end
            I_RRMOV: begin
              state <= S_DONE;
              if (ra[3] || rb[3] || !ce[1]) run_st <= ST_INS;
              else begin
                if (ce[0]) regs[rb[2:0]] <= va;
                pc <= pc + 32'd2;
              end
            end
            I_IRMOV: begin
              state <= S_DONE;
              if (ra != RNONE || rb[3] || fn != 4'd0) run_st <= ST_INS;
              else begin regs[rb[2:0]] <= imm; pc <= pc + 32'd6; end
            end
            I_RMMOV, I_MRMOV: begin
              if (ra[3] || rb[3] || fn != 4'd0) begin
                run_st <= ST_INS; state <= S_DONE;
              end else if (eab > LAST_WORD) begin
                run_st <= ST_ADR; state <= S_DONE;
              end else begin
                ea <= eab; wval <= va; dst_reg <= ra[2:0]; dst_pc <= 1'b0;
                state <= (ic == I_RMMOV) ? S_DWR : S_DRD;
              end
            end
            I_OP: begin
              state <= S_DONE;
              if (ra[3] || rb[3] || fn > 4'd3) run_st <= ST_INS;
              else begin
                regs[rb[2:0]] <= alu;
                cc <= {alu == 32'd0, alu[31], alu_o};
                pc <= pc + 32'd2;
              end
            end
            I_JXX: begin
              state <= S_DONE;
              if (!ce[1]) run_st <= ST_INS;
              else pc <= ce[0] ? imm : pc + 32'd5;
            end
            I_CALL: begin
              regs[ESP_IDX] <= sp_m4;
              if (sp_m4 > LAST_WORD) begin
                run_st <= ST_ADR; state <= S_DONE;
              end else begin ea <= sp_m4; wval <= pc + 32'd5; state <= S_DWR; end
            end
            I_RET: begin
              if (vsp > LAST_WORD) begin
                run_st <= ST_ADR; state <= S_DONE;
              end else begin ea <= vsp; dst_pc <= 1'b1; state <= S_DRD; end
            end
            I_PUSH: begin
              if (ra[3] || rb != RNONE || fn != 4'd0) begin
                run_st <= ST_INS; state <= S_DONE;
              end else begin
                regs[ESP_IDX] <= sp_m4;
                if (sp_m4 > LAST_WORD) begin
                  run_st <= ST_ADR; state <= S_DONE;
                end else begin ea <= sp_m4; wval <= va; state <= S_DWR; end
              end
            end
            I_POP: begin
              if (ra[3] || rb != RNONE || fn != 4'd0) begin
                run_st <= ST_INS; state <= S_DONE;
              end else begin
                regs[ESP_IDX] <= sp_p4;
                if (vsp > LAST_WORD) begin
                  run_st <= ST_ADR; state <= S_DONE;
                end else begin
                  ea <= vsp; dst_reg <= ra[2:0]; dst_pc <= 1'b0; state <= S_DRD;
                end
              end
            end
            default: begin run_st <= ST_INS; state <= S_DONE; end
          endcase
        end
        S_DWR: begin
          dcnt <= dcnt + 3'd1;
          if (dcnt == 3'd3) begin
            pc <= (ic == I_CALL) ? imm : pc + ((ic == I_PUSH) ? 32'd2 : 32'd6);
            state <= S_DONE;
          end
        end
        S_DRD, S_WORD: begin
          dcnt <= dcnt + 3'd1;
          if (dcnt != 3'd0) rd_word <= rd_acc;
          if (dcnt == 3'd4) begin
            if (state == S_WORD) dout <= rd_acc;
            else if (dst_pc) begin
              pc <= rd_acc; regs[ESP_IDX] <= sp_p4;
            end else begin
              regs[dst_reg] <= rd_acc;
              pc <= pc + ((ic == I_POP) ? 32'd2 : 32'd6);
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_data <= {3'b0, dout, cc, pc, run_st};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // status only ever leaves a stop state through reset
  assert property (@(posedge clk) disable iff (rst)
    $past(run_st) != ST_AOK && !$past(rst) |-> run_st == $past(run_st))
    else $error("status left a stop state");
  // a stalled result holds its data
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");
  // memory is written only in clear, data write or load phases
  assert property (@(posedge clk) disable iff (rst)
    req.we |-> (state == S_CLR || state == S_DWR || load_we))
    else $error("unexpected memory write");
endmodule

>>> sim/tb.sv
// testbench for the y86 executor: generated programs checked against a built-in predictor
module tb import y86_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] addr;
    logic [7:0]  byte_val;
    logic [2:0]  ridx;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] pc;
    logic [2:0]  flags;
    logic [31:0] data;
  } resp_t;

  localparam int CODE_TOP = 2900;
  localparam int DATA_LO  = 3072;
  localparam int STACK_LO = 3400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // mode, address, load_byte, register_index
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // status, program_counter, flags, read_data

  y86_instruction_executor u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #1 clk = ~clk;

  // predicted machine state
  logic [7:0]  mem_m [0:MEM_BYTES-1];
  logic [31:0] regs_m [0:7];
  logic [31:0] pc_m;
  logic [2:0]  cc_m;
  logic [1:0]  stat_m;

  cmd_t  cmd_q[$];
  resp_t resp_q[$];
  bit    failed = 0;
  bit    gen_done = 0;
  bit    took = 0;
  int    cyc = 0;

  function automatic bit word_ok(logic [31:0] a);
    return a <= LAST_WORD;
  endfunction

  function automatic logic [31:0] rd_word(logic [31:0] a);
    return {mem_m[a+3], mem_m[a+2], mem_m[a+1], mem_m[a]};
  endfunction

  function automatic void wr_word(logic [31:0] a, logic [31:0] v);
    for (int i = 0; i < 4; i++) mem_m[a+i] = v[8*i +: 8];
  endfunction

  // 1 taken, 0 not taken, -1 undefined condition
  function automatic int cond_taken(logic [2:0] cc, logic [3:0] f);
    logic lt;
    lt = cc[1] ^ cc[0];
    case (f)
      4'd0: return 1;
      4'd1: return lt | cc[2];
      4'd2: return lt;
      4'd3: return cc[2];
      4'd4: return !cc[2];
      4'd5: return !lt;
      4'd6: return !lt && !cc[2];
      default: return -1;
    endcase
  endfunction

  // one instruction on the predicted state, returns the new status
  function automatic logic [1:0] run_insn();
    logic [31:0] pc, np, imm, va, vb, ve;
    logic [3:0]  ic, fn, ra, rb;
    logic        ov;
    int          t;
    pc = pc_m; ra = RNONE; rb = RNONE; imm = '0; ov = 1'b0;
    if (pc >= MEM_BYTES) return ST_ADR;
    ic = mem_m[pc][7:4];
    fn = mem_m[pc][3:0];
    np = pc + 1;
    if (!(ic inside {I_HALT, I_NOP, I_JXX, I_CALL, I_RET})) begin
      if (np >= MEM_BYTES) return ST_ADR;
      ra = mem_m[np][7:4];
      rb = mem_m[np][3:0];
      np++;
    end
    if (ic inside {I_IRMOV, I_RMMOV, I_MRMOV, I_JXX, I_CALL}) begin
      if (!word_ok(np)) return ST_ADR;
      imm = rd_word(np);
      np += 4;
    end
    case (ic)
      I_HALT: return ST_HLT;
      I_NOP: begin
        pc_m = np;
        return ST_AOK;
      end
      I_RRMOV: begin
        if (ra > 7 || rb > 7) return ST_INS;
        t = cond_taken(cc_m, fn);
        if (t < 0) return ST_INS;
        if (t == 1) regs_m[rb[2:0]] = regs_m[ra[2:0]];
        pc_m = np;
        return ST_AOK;
      end
      I_IRMOV: begin
        if (ra != RNONE || rb > 7 || fn != 0) return ST_INS;
        regs_m[rb[2:0]] = imm;
        pc_m = np;
        return ST_AOK;
      end
      I_RMMOV, I_MRMOV: begin
        if (ra > 7 || rb > 7 || fn != 0) return ST_INS;
        ve = regs_m[rb[2:0]] + imm;
        if (!word_ok(ve)) return ST_ADR;
        if (ic == I_RMMOV) wr_word(ve, regs_m[ra[2:0]]);
        else regs_m[ra[2:0]] = rd_word(ve);
        pc_m = np;
        return ST_AOK;
      end
      I_OP: begin
        if (ra > 7 || rb > 7 || fn > 3) return ST_INS;
        va = regs_m[ra[2:0]];
        vb = regs_m[rb[2:0]];
        case (fn)
          4'd0: begin
            ve = vb + va;
            ov = (~(va[31] ^ vb[31])) & (ve[31] ^ va[31]);
          end
          4'd1: begin
            ve = vb - va;
            ov = (va[31] ^ vb[31]) & (vb[31] ^ ve[31]);
          end
          4'd2: ve = vb & va;
          default: ve = vb ^ va;
        endcase
        cc_m = {ve == 0, ve[31], ov};
        regs_m[rb[2:0]] = ve;
        pc_m = np;
        return ST_AOK;
      end
      I_JXX: begin
        t = cond_taken(cc_m, fn);
        if (t < 0) return ST_INS;
        pc_m = (t == 1) ? imm : np;
        return ST_AOK;
      end
      I_CALL: begin
        ve = regs_m[ESP_IDX] - 4;
        regs_m[ESP_IDX] = ve;
        if (!word_ok(ve)) return ST_ADR;
        wr_word(ve, np);
        pc_m = imm;
        return ST_AOK;
      end
      I_RET: begin
        va = regs_m[ESP_IDX];
        if (!word_ok(va)) return ST_ADR;
        regs_m[ESP_IDX] = va + 4;
        pc_m = rd_word(va);
        return ST_AOK;
      end
      I_PUSH: begin
        if (ra > 7 || rb != RNONE || fn != 0) return ST_INS;
        va = regs_m[ra[2:0]];
        ve = regs_m[ESP_IDX] - 4;
        regs_m[ESP_IDX] = ve;
        if (!word_ok(ve)) return ST_ADR;
        wr_word(ve, va);
        pc_m = np;
        return ST_AOK;
      end
      I_POP: begin
        if (ra > 7 || rb != RNONE || fn != 0) return ST_INS;
        va = regs_m[ESP_IDX];
        regs_m[ESP_IDX] = va + 4;
        if (!word_ok(va)) return ST_ADR;
        regs_m[ra[2:0]] = rd_word(va);
        pc_m = np;
        return ST_AOK;
      end
      default: return ST_INS;
    endcase
  endfunction

  // queue one transaction and its predicted response
  task automatic send(logic [1:0] mode, logic [11:0] addr, logic [7:0] b, logic [2:0] r);
    cmd_t  c;
    resp_t e;
    c = '{mode: mode, addr: addr, byte_val: b, ridx: r};
    e.data = '0;
    case (mode)
      MODE_LOAD: mem_m[addr] = b;
      MODE_EXEC: if (stat_m == ST_AOK) stat_m = run_insn();
      MODE_RDMEM: if (word_ok({20'd0, addr})) e.data = rd_word({20'd0, addr});
      default: e.data = regs_m[r];
    endcase
    e.status = stat_m;
    e.pc = pc_m;
    e.flags = cc_m;
    cmd_q.push_back(c);
    resp_q.push_back(e);
  endtask

  // encode an instruction at the current pc, load it, then execute it
  task automatic do_insn(logic [3:0] ic, logic [3:0] fn, logic [3:0] ra, logic [3:0] rb,
                         logic [31:0] imm);
    logic [7:0] enc [0:5];
    int n, off;
    enc[0] = {ic, fn};
    off = (ic inside {I_HALT, I_NOP, I_JXX, I_CALL, I_RET}) ? 1 : 2;
    enc[1] = {ra, rb};
    n = off;
    if (ic inside {I_IRMOV, I_RMMOV, I_MRMOV, I_JXX, I_CALL}) begin
      for (int i = 0; i < 4; i++) enc[off+i] = imm[8*i +: 8];
      n = off + 4;
    end
    for (int i = 0; i < n; i++)
      if (pc_m + i < MEM_BYTES) send(MODE_LOAD, 12'(pc_m + i), enc[i], 3'($urandom));
    send(MODE_EXEC, 12'($urandom), 8'($urandom), 3'($urandom));
  endtask

  function automatic logic [3:0] pick_dst();
    logic [3:0] r;
    do r = 4'($urandom_range(0, 7)); while (r == 4'(ESP_IDX));
    return r;
  endfunction

  // one well-formed random instruction that keeps pc and stack in range
  task automatic rand_insn();
    logic [31:0] esp, tgt;
    int kind;
    esp = regs_m[ESP_IDX];
    kind = $urandom_range(0, 10);
    if (pc_m > CODE_TOP) begin
      do_insn(I_JXX, 4'd0, RNONE, RNONE, $urandom_range(0, 255));
      return;
    end
    if (esp < STACK_LO || esp > MEM_BYTES - 4) begin
      do_insn(I_IRMOV, 4'd0, RNONE, 4'(ESP_IDX), $urandom_range(STACK_LO + 200, MEM_BYTES - 4));
      return;
    end
    tgt = $urandom_range(DATA_LO, MEM_BYTES - 4);
    case (kind)
      0: do_insn(I_NOP, 4'($urandom), RNONE, RNONE, 0);
      1: do_insn(I_RRMOV, 4'($urandom_range(0, 6)), 4'($urandom_range(0, 7)), pick_dst(), 0);
      2: begin
        tgt = ($urandom_range(0, 3) == 0) ? {$urandom_range(0, 1) ? 32'hffff_ffff : 32'h0}
                                          : 32'($urandom);
        do_insn(I_IRMOV, 4'd0, RNONE, pick_dst(), tgt);
      end
      3: begin
        kind = $urandom_range(0, 7);
        do_insn(I_RMMOV, 4'd0, 4'($urandom_range(0, 7)), 4'(kind), tgt - regs_m[kind]);
      end
      4: begin
        kind = $urandom_range(0, 7);
        do_insn(I_MRMOV, 4'd0, pick_dst(), 4'(kind), tgt - regs_m[kind]);
      end
      5: do_insn(I_OP, 4'($urandom_range(0, 3)), 4'($urandom_range(0, 7)), pick_dst(), 0);
      6: do_insn(I_JXX, 4'($urandom_range(0, 6)), RNONE, RNONE, $urandom_range(0, CODE_TOP));
      7: if (esp >= STACK_LO + 4) do_insn(I_CALL, 4'($urandom), RNONE, RNONE,
                                          $urandom_range(0, CODE_TOP));
         else do_insn(I_NOP, 4'd0, RNONE, RNONE, 0);
      8: begin
        // return address placed on the stack first
        tgt = $urandom_range(0, CODE_TOP);
        for (int i = 0; i < 4; i++) send(MODE_LOAD, 12'(esp + i), tgt[8*i +: 8], 3'd0);
        do_insn(I_RET, 4'($urandom), RNONE, RNONE, 0);
      end
      9: if (esp >= STACK_LO + 4)
           do_insn(I_PUSH, 4'd0, 4'($urandom_range(0, 7)), RNONE, 0);
         else do_insn(I_NOP, 4'd0, RNONE, RNONE, 0);
      default: do_insn(I_POP, 4'd0, pick_dst(), RNONE, 0);
    endcase
  endtask

  // one stopping event, then show that the status sticks
  task automatic end_fault();
    case ($urandom_range(0, 8))
      0: do_insn(I_HALT, 4'($urandom), RNONE, RNONE, 0);
      1: do_insn(4'($urandom_range(12, 15)), 4'($urandom), 4'd0, 4'd0, 0);
      2: do_insn(I_OP, 4'($urandom_range(0, 3)), 4'($urandom_range(8, 14)), 4'd1, 0);
      3: do_insn(I_IRMOV, 4'd0, 4'($urandom_range(0, 14)), 4'd2, 32'h1234);
      4: do_insn(I_JXX, 4'($urandom_range(7, 15)), RNONE, RNONE, 0);
      5: begin
        do_insn(I_IRMOV, 4'd0, RNONE, 4'(ESP_IDX), 32'd2);
        do_insn(I_PUSH, 4'd0, 4'd0, RNONE, 0);
      end
      6: do_insn(I_MRMOV, 4'd0, 4'd1, 4'd0, 32'($urandom_range(0, 1) ? 4093 : -4) - regs_m[0]);
      7: begin
        do_insn(I_IRMOV, 4'd0, RNONE, 4'(ESP_IDX), 32'd4095);
        do_insn(I_POP, 4'd0, 4'd1, RNONE, 0);
      end
      default: begin
        do_insn(I_JXX, 4'd0, RNONE, RNONE, 32'd4092);
        do_insn(I_IRMOV, 4'd0, RNONE, 4'd1, 32'd7);
      end
    endcase
    for (int i = 0; i < 4; i++) rand_insn();
    for (int i = 0; i < 8; i++) send(MODE_RDREG, 12'd0, 8'd0, 3'(i));
  endtask

  // stimulus and predicted responses
  initial begin
    int noise;
    for (int i = 0; i < MEM_BYTES; i++) mem_m[i] = '0;
    for (int i = 0; i < 8; i++) regs_m[i] = '0;
    pc_m = '0; cc_m = 3'd4; stat_m = ST_AOK;

    // directed: extremes, flag cases and every move condition
    send(MODE_RDREG, 12'd0, 8'd0, 3'd7);
    send(MODE_LOAD, 12'hfff, 8'hff, 3'd7);
    send(MODE_RDMEM, 12'hffc, 8'd0, 3'd0);
    send(MODE_RDMEM, 12'hffd, 8'd0, 3'd0);
    do_insn(I_IRMOV, 4'd0, RNONE, 4'(ESP_IDX), 32'd4092);
    do_insn(I_IRMOV, 4'd0, RNONE, 4'd0, 32'h7fff_ffff);
    do_insn(I_IRMOV, 4'd0, RNONE, 4'd1, 32'h8000_0000);
    do_insn(I_OP, 4'd0, 4'd0, 4'd0, 0);
    do_insn(I_OP, 4'd1, 4'd0, 4'd1, 0);
    do_insn(I_OP, 4'd2, 4'd1, 4'd2, 0);
    do_insn(I_OP, 4'd3, 4'd1, 4'd1, 0);
    for (int f = 0; f <= 6; f++) do_insn(I_RRMOV, 4'(f), 4'd0, 4'(f == 4 ? 7 : f), 0);
    do_insn(I_PUSH, 4'd0, 4'd0, RNONE, 0);
    do_insn(I_POP, 4'd0, 4'd3, RNONE, 0);
    send(MODE_RDREG, 12'd0, 8'd0, 3'd3);

    // random programs with some loose reads and loads
    while (cmd_q.size() < 1850) begin
      noise = $urandom_range(0, 99);
      if (noise < 15)
        send(2'($urandom_range(0, 1) ? MODE_RDMEM : MODE_RDREG), 12'($urandom),
             8'($urandom), 3'($urandom));
      else if (noise < 20)
        send(MODE_LOAD, 12'($urandom), 8'($urandom), 3'($urandom));
      else
        rand_insn();
    end
    end_fault();
    gen_done = 1;
  end

  // reset and end of run
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    wait (gen_done);
    wait (cmd_q.size() == 0 && !s_axis_tvalid);
    wait (resp_q.size() == 0);
    repeat (40) @(posedge clk);
    if (!failed && resp_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    took <= s_axis_tvalid && s_axis_tready;
  end

  function automatic bit idle_now();
    return !(cyc >= 10000 && cyc < 16000) && $urandom_range(0, 99) < 16;
  endfunction

  // driver: present the next transaction at the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      m_axis_tready <= !idle_now();
      if (!s_axis_tvalid || took) begin
        if (cmd_q.size() > 0 && gen_done && !idle_now()) begin
          s_axis_tdata <= {7'd0, cmd_q[0].ridx, cmd_q[0].byte_val, cmd_q[0].addr,
                           cmd_q[0].mode};
          s_axis_tvalid <= 1'b1;
          void'(cmd_q.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each response with the oldest prediction
  always @(posedge clk) begin
    resp_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{status: m_axis_tdata[1:0], pc: m_axis_tdata[33:2],
              flags: m_axis_tdata[36:34], data: m_axis_tdata[68:37]};
      if (resp_q.size() == 0) begin
        $display("%0t: response with nothing expected, got %h", $time, got);
        failed = 1;
      end else begin
        want = resp_q.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
          failed = 1;
        end
        if (got.pc !== want.pc) begin
          $display("%0t: pc expected %h got %h", $time, want.pc, got.pc);
          failed = 1;
        end
        if (got.flags !== want.flags) begin
          $display("%0t: flags expected %b got %b", $time, want.flags, got.flags);
          failed = 1;
        end
        if (got.data !== want.data) begin
          $display("%0t: read_data expected %h got %h", $time, want.data, got.data);
          failed = 1;
        end
      end
    end
  end
endmodule
